FILE: src/battery_load_shedding_controller_core_macros.svh
// Assertion macros shared by the load shedding controller RTL.
// Needs clk_i and rst_ni in the scope that uses them.
`ifndef BATTERY_LOAD_SHEDDING_CONTROLLER_CORE_MACROS_SVH
`define BATTERY_LOAD_SHEDDING_CONTROLLER_CORE_MACROS_SVH

// Same-cycle implication, checked outside reset
`define BLSC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset
`define BLSC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/blsc_pkg.sv
// Shared types and constants of the load shedding controller.
// No dependencies; imported by every module of the block.
`default_nettype none

package blsc_pkg;

  // Field widths
  localparam int unsigned ADC_W    = 16;
  localparam int unsigned LIGHT_W  = 11;
  localparam int unsigned RATIO_W  = 11;
  localparam int unsigned TICK_W   = 8;
  localparam int unsigned CNT_W    = 3;
  localparam int unsigned THR_W    = 15;
  localparam int unsigned MV_W     = 17;
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned ADDR_W   = 5;
  localparam int unsigned RSHIFT   = 10;

  // Safe band and reset values
  localparam logic [MV_W-1:0]    SAFE_LOW_MV   = 17'd10000;
  localparam logic [MV_W-1:0]    SAFE_HIGH_MV  = 17'd15000;
  localparam logic [MV_W-1:0]    MEAN_RST      = 17'd12000;
  localparam logic [TICK_W-1:0]  TICK_RST      = 8'd255;
  localparam logic [RATIO_W-1:0] RATIO_RST     = 11'd981;
  localparam logic [TICK_W-1:0]  INTERVAL_RST  = 8'd30;
  localparam logic [LIGHT_W-1:0] NIGHT_RST     = 11'd300;
  localparam logic [CNT_W-1:0]   RELAY_CNT_RST = 3'd7;
  localparam logic [THR_W-1:0]   SHED_RST      = 15'd13100;
  localparam logic [THR_W-1:0]   ADD_RST       = 15'd12800;
  localparam logic [THR_W-1:0]   FRIDGE_ON_RST = 15'd12700;
  localparam logic [THR_W-1:0]   FRIDGE_OFF_RST = 15'd12500;

  // Register map
  typedef enum logic [2:0] {
    REG_RATIO      = 3'd0,
    REG_INTERVAL   = 3'd1,
    REG_NIGHT      = 3'd2,
    REG_RELAY_CNT  = 3'd3,
    REG_SHED       = 3'd4,
    REG_ADD        = 3'd5,
    REG_FRIDGE_ON  = 3'd6,
    REG_FRIDGE_OFF = 3'd7
  } blsc_reg_e;

  // Per-request decision flags carried down the pipeline
  typedef struct packed {
    logic eval;   // interval elapsed on a tick
    logic day;    // evaluation with light above threshold
    logic shift;  // request pushes a sample into the window
  } blsc_flags_t;

  // Thresholds used by the load policy
  typedef struct packed {
    logic [CNT_W-1:0] relay_count;
    logic [THR_W-1:0] shed_above;
    logic [THR_W-1:0] add_below;
    logic [THR_W-1:0] fridge_on;
    logic [THR_W-1:0] fridge_off;
  } blsc_thr_t;

endpackage

`default_nettype wire

FILE: src/blsc_cell.sv
// One window cell: holds a millivolt sample, takes its neighbor's on shift.
// Depends on blsc_pkg for the sample width.
`default_nettype none

module blsc_cell (
  input  wire                       clk_i,
  input  wire                       rst_ni,
  input  wire                       shift_i,
  input  wire [blsc_pkg::MV_W-1:0]  sample_i,
  output logic [blsc_pkg::MV_W-1:0] sample_o
);
  import blsc_pkg::*;

  logic [MV_W-1:0] sample_q;

  // Take the neighbor's sample on each shift
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sample_q <= '0;
    end else if (shift_i) begin
      sample_q <= sample_i;
    end
  end

  assign sample_o = sample_q;

endmodule

`default_nettype wire

FILE: src/blsc_window.sv
// Sample window: a row of blsc_cell with a running total and mean stage.
// Depends on blsc_pkg and blsc_cell.
`default_nettype none

module blsc_window #(
  parameter int unsigned WINDOW = 10
) (
  input  wire                       clk_i,
  input  wire                       rst_ni,
  input  wire                       shift_i,
  input  wire [blsc_pkg::MV_W-1:0]  sample_i,
  input  wire                       mean_en_i,
  output logic [blsc_pkg::MV_W-1:0] mean_o
);
  import blsc_pkg::*;

  localparam int unsigned IDX_W = $clog2(WINDOW);
  localparam int unsigned TOT_W = MV_W + IDX_W;
  // Reciprocal of WINDOW, exact floor for any total below 2**TOT_W
  localparam int unsigned K     = TOT_W + IDX_W;
  localparam int unsigned M_W   = TOT_W + 2;
  localparam int unsigned P_W   = TOT_W + M_W;
  localparam logic [63:0] RECIP64 =
    ((64'd1 << K) + 64'(WINDOW) - 64'd1) / 64'(WINDOW);
  localparam logic [M_W-1:0] RECIP = RECIP64[M_W-1:0];

  logic [MV_W-1:0]  tap [WINDOW+1];
  logic [TOT_W-1:0] total_q, total_d;
  logic [P_W-1:0]   prod;
  logic [MV_W-1:0]  mean_q;

  assign tap[WINDOW] = sample_i;

  // Row of cells, oldest sample in cell 0
  for (genvar i = 0; i < WINDOW; i++) begin : g_cell
    blsc_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .shift_i  (shift_i),
      .sample_i (tap[i+1]),
      .sample_o (tap[i])
    );
  end

  // Drop the oldest sample, add the new one
  assign total_d = total_q - TOT_W'(tap[0]) + TOT_W'(sample_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= '0;
    end else if (shift_i) begin
      total_q <= total_d;
    end
  end

  // Mean by reciprocal multiply
  assign prod = P_W'(total_q) * P_W'(RECIP);

  always_ff @(posedge clk_i) begin
    if (mean_en_i) begin
      mean_q <= prod[K +: MV_W];
    end
  end

  assign mean_o = mean_q;

endmodule

`default_nettype wire

FILE: src/blsc_policy.sv
// Load policy: relay count, fridge, alarm and night state; doubles as the
// result register. Depends on blsc_pkg and the assertion macro header.
`default_nettype none

module blsc_policy #(
  parameter int unsigned RELAY_OUTPUTS = 7
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          load_i,
  input  wire blsc_pkg::blsc_flags_t   flags_i,
  input  wire [blsc_pkg::MV_W-1:0]     mean_i,
  input  wire blsc_pkg::blsc_thr_t     thr_i,
  output logic [RELAY_OUTPUTS-1:0]     relay_mask_o,
  output logic [blsc_pkg::CNT_W-1:0]   relays_closed_o,
  output logic                         fridge_enabled_o,
  output logic                         alarm_o,
  output logic                         night_seen_o,
  output logic                         evaluated_o,
  output logic [blsc_pkg::MV_W-1:0]    mean_mv_o
);
  import blsc_pkg::*;

  `include "battery_load_shedding_controller_core_macros.svh"

  logic [CNT_W-1:0] closed_q, closed_d;
  logic             fridge_q, fridge_d;
  logic             alarm_q, alarm_d;
  logic             night_q, night_d;
  logic             eval_q;
  logic [MV_W-1:0]  mean_q, mean_d;

  // Evaluate one request against current state
  always_comb begin
    closed_d = closed_q;
    fridge_d = fridge_q;
    alarm_d  = alarm_q;
    night_d  = night_q;
    mean_d   = mean_q;
    if (flags_i.eval) begin
      if (!flags_i.day) begin
        night_d  = 1'b1;
        alarm_d  = 1'b0;
        closed_d = '0;
        fridge_d = 1'b0;
      end else begin
        night_d = 1'b0;
        mean_d  = mean_i;
        if (mean_i < SAFE_LOW_MV || mean_i > SAFE_HIGH_MV) begin
          alarm_d  = 1'b1;
          closed_d = '0;
          fridge_d = 1'b0;
        end else begin
          alarm_d = 1'b0;
          // Step down first, then step up on the result
          if (mean_i > MV_W'(thr_i.shed_above) && closed_d != '0) begin
            closed_d = closed_d - CNT_W'(1);
          end
          if (mean_i < MV_W'(thr_i.add_below) && closed_d < thr_i.relay_count) begin
            closed_d = closed_d + CNT_W'(1);
          end
          if (mean_i > MV_W'(thr_i.fridge_on)) begin
            fridge_d = 1'b1;
          end
          if (mean_i < MV_W'(thr_i.fridge_off)) begin
            fridge_d = 1'b0;
          end
        end
      end
    end
  end

  // Commit state as the request enters the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      closed_q <= RELAY_CNT_RST;
      fridge_q <= 1'b0;
      alarm_q  <= 1'b0;
      night_q  <= 1'b0;
      eval_q   <= 1'b0;
      mean_q   <= MEAN_RST;
    end else if (load_i) begin
      closed_q <= closed_d;
      fridge_q <= fridge_d;
      alarm_q  <= alarm_d;
      night_q  <= night_d;
      eval_q   <= flags_i.eval;
      mean_q   <= mean_d;
    end
  end

  // Relay i closed when i is below the closed count
  always_comb begin
    for (int i = 0; i < RELAY_OUTPUTS; i++) begin
      relay_mask_o[i] = ({1'b0, closed_q} > 4'(i));
    end
  end

  assign relays_closed_o  = closed_q;
  assign fridge_enabled_o = fridge_q;
  assign alarm_o          = alarm_q;
  assign night_seen_o     = night_q;
  assign evaluated_o      = eval_q;
  assign mean_mv_o        = mean_q;

  `BLSC_ASSERT_IMP(a_alarm_not_night, alarm_q, !night_q, "alarm and night both set")
  `BLSC_ASSERT_IMP(a_alarm_cuts, alarm_q, closed_q == '0 && !fridge_q, "alarm left loads on")
  `BLSC_ASSERT_IMP(a_night_cuts, night_q, closed_q == '0 && !fridge_q, "night left loads on")
  `BLSC_ASSERT_NXT(a_hold_idle, !load_i, $stable(closed_q) && $stable(mean_q),
                   "state moved without a request")

endmodule

`default_nettype wire

FILE: src/battery_load_shedding_controller_core.sv
// Top level of the battery load shedding controller: config registers,
// interval counter, sample scaling and pipeline control.
// Depends on blsc_pkg, blsc_window and blsc_policy.
//
//   channel  direction  handshake                 payload
//   in       to block   in_valid_i / in_stall_o   op_i, adc_sum_i, light_sum_i
//   out      from block out_valid_o / out_stall_i relay_mask_o .. mean_mv_o
//   cfg      to block   APB psel/penable/pready   paddr, pwdata, prdata
//
// One request per cycle sustained while no result is stalled; a request gets its
// scale multiply at acceptance, then passes window shift, mean multiply and policy
// into the result register. Each stage fills whenever it is empty, so requests
// keep entering while a result is stalled until all four stages hold data.
// Reset zeroes window cells and total, presets counter and policy; no clearing pass.
`default_nettype none

module battery_load_shedding_controller_core #(
  parameter int unsigned WINDOW        = 10,
  parameter int unsigned RELAY_OUTPUTS = 7
) (
  input  wire                             clk_i,
  input  wire                             rst_ni,
  // Request channel
  input  wire                             in_valid_i,
  output logic                            in_stall_o,
  input  wire                             op_i,
  input  wire [blsc_pkg::ADC_W-1:0]       adc_sum_i,
  input  wire [blsc_pkg::LIGHT_W-1:0]     light_sum_i,
  // Result channel
  output logic                            out_valid_o,
  input  wire                             out_stall_i,
  output logic [RELAY_OUTPUTS-1:0]        relay_mask_o,
  output logic [blsc_pkg::CNT_W-1:0]      relays_closed_o,
  output logic                            fridge_enabled_o,
  output logic                            alarm_o,
  output logic                            night_seen_o,
  output logic                            evaluated_o,
  output logic [blsc_pkg::MV_W-1:0]       mean_mv_o,
  // Configuration port
  input  wire                             psel,
  input  wire                             penable,
  input  wire                             pwrite,
  input  wire [blsc_pkg::ADDR_W-1:0]      paddr,
  input  wire [blsc_pkg::DATA_W-1:0]      pwdata,
  output logic [blsc_pkg::DATA_W-1:0]     prdata,
  output logic                            pready
);
  import blsc_pkg::*;

  localparam int unsigned PROD_W = ADC_W + RATIO_W;

  // Configuration registers
  logic [RATIO_W-1:0] ratio_q;
  logic [TICK_W-1:0]  interval_q;
  logic [LIGHT_W-1:0] night_q;
  blsc_thr_t          thr_q;
  blsc_reg_e          reg_sel;
  logic               cfg_wr;

  // Pipeline
  logic               accept;
  logic               s1_valid_q, s2_valid_q, s3_valid_q, out_valid_q;
  logic               rdy1, rdy2, rdy3, out_rdy;
  logic               adv1, adv2, adv3;
  blsc_flags_t        s1_flags_q, s2_flags_q, s3_flags_q, in_flags;
  logic [MV_W-1:0]    s1_mv_q;
  logic [PROD_W-1:0]  scale_prod;
  logic [MV_W-1:0]    mean_cand;
  logic [TICK_W-1:0]  tick_q, tick_d;
  logic [TICK_W:0]    tick_next;
  logic               elapsed;

  // Register decode
  assign reg_sel = blsc_reg_e'(paddr[ADDR_W-1:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ratio_q          <= RATIO_RST;
      interval_q       <= INTERVAL_RST;
      night_q          <= NIGHT_RST;
      thr_q.relay_count <= RELAY_CNT_RST;
      thr_q.shed_above <= SHED_RST;
      thr_q.add_below  <= ADD_RST;
      thr_q.fridge_on  <= FRIDGE_ON_RST;
      thr_q.fridge_off <= FRIDGE_OFF_RST;
    end else if (cfg_wr) begin
      unique case (reg_sel)
        REG_RATIO:      ratio_q           <= pwdata[RATIO_W-1:0];
        REG_INTERVAL:   interval_q        <= pwdata[TICK_W-1:0];
        REG_NIGHT:      night_q           <= pwdata[LIGHT_W-1:0];
        REG_RELAY_CNT:  thr_q.relay_count <= pwdata[CNT_W-1:0];
        REG_SHED:       thr_q.shed_above  <= pwdata[THR_W-1:0];
        REG_ADD:        thr_q.add_below   <= pwdata[THR_W-1:0];
        REG_FRIDGE_ON:  thr_q.fridge_on   <= pwdata[THR_W-1:0];
        REG_FRIDGE_OFF: thr_q.fridge_off  <= pwdata[THR_W-1:0];
        default: ;
      endcase
    end
  end

  // Register readback
  always_comb begin
    unique case (reg_sel)
      REG_RATIO:      prdata = DATA_W'(ratio_q);
      REG_INTERVAL:   prdata = DATA_W'(interval_q);
      REG_NIGHT:      prdata = DATA_W'(night_q);
      REG_RELAY_CNT:  prdata = DATA_W'(thr_q.relay_count);
      REG_SHED:       prdata = DATA_W'(thr_q.shed_above);
      REG_ADD:        prdata = DATA_W'(thr_q.add_below);
      REG_FRIDGE_ON:  prdata = DATA_W'(thr_q.fridge_on);
      REG_FRIDGE_OFF: prdata = DATA_W'(thr_q.fridge_off);
      default:        prdata = '0;
    endcase
  end

  // Stage handshake: each stage fills when empty or draining
  assign out_rdy    = !out_valid_q || !out_stall_i;
  assign rdy3       = !s3_valid_q || out_rdy;
  assign rdy2       = !s2_valid_q || rdy3;
  assign rdy1       = !s1_valid_q || rdy2;
  assign adv3       = s3_valid_q && out_rdy;
  assign adv2       = s2_valid_q && rdy3;
  assign adv1       = s1_valid_q && rdy2;
  assign in_stall_o = !rdy1;
  assign accept     = in_valid_i && rdy1;

  // Interval counter and request classification
  assign tick_next = {1'b0, tick_q} + (TICK_W+1)'(1);
  assign elapsed   = tick_next >= {1'b0, interval_q};

  always_comb begin
    tick_d         = tick_q;
    in_flags.eval  = 1'b0;
    in_flags.day   = 1'b0;
    if (!op_i) begin
      if (elapsed) begin
        tick_d        = '0;
        in_flags.eval = 1'b1;
        in_flags.day  = light_sum_i > night_q;
      end else begin
        tick_d = tick_next[TICK_W-1:0];
      end
    end
    in_flags.shift = op_i || in_flags.day;
  end

  assign scale_prod = PROD_W'(adc_sum_i) * PROD_W'(ratio_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q      <= TICK_RST;
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        tick_q <= tick_d;
      end
      if (accept) begin
        s1_valid_q <= 1'b1;
      end else if (adv1) begin
        s1_valid_q <= 1'b0;
      end
      if (adv1) begin
        s2_valid_q <= 1'b1;
      end else if (adv2) begin
        s2_valid_q <= 1'b0;
      end
      if (adv2) begin
        s3_valid_q <= 1'b1;
      end else if (adv3) begin
        s3_valid_q <= 1'b0;
      end
      if (adv3) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Stage payloads
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_flags_q <= in_flags;
      s1_mv_q    <= scale_prod[RSHIFT +: MV_W];
    end
    if (adv1) begin
      s2_flags_q <= s1_flags_q;
    end
    if (adv2) begin
      s3_flags_q <= s2_flags_q;
    end
  end

  blsc_window #(
    .WINDOW (WINDOW)
  ) u_window (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .shift_i   (adv1 && s1_flags_q.shift),
    .sample_i  (s1_mv_q),
    .mean_en_i (adv2),
    .mean_o    (mean_cand)
  );

  blsc_policy #(
    .RELAY_OUTPUTS (RELAY_OUTPUTS)
  ) u_policy (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .load_i           (adv3),
    .flags_i          (s3_flags_q),
    .mean_i           (mean_cand),
    .thr_i            (thr_q),
    .relay_mask_o     (relay_mask_o),
    .relays_closed_o  (relays_closed_o),
    .fridge_enabled_o (fridge_enabled_o),
    .alarm_o          (alarm_o),
    .night_seen_o     (night_seen_o),
    .evaluated_o      (evaluated_o),
    .mean_mv_o        (mean_mv_o)
  );

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire
